>>> rtl/core/ilid_pkg.sv
// Package for the indexed list: sizes, opcodes, status codes and cell control.
package ilid_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned ST_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_PREPEND   = 3'd1,
    OP_INSERT_AT = 3'd2,
    OP_READ_AT   = 3'd3,
    OP_DROP_HEAD = 3'd4,
    OP_DROP_TAIL = 3'd5,
    OP_DROP_AT   = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

>>> rtl/core/ilid_cell.sv
// One list cell: holds one entry, loads a new value or shifts from its left or right neighbor.
module ilid_cell #(
  parameter int unsigned DataW = ilid_pkg::DATA_W,
  parameter int unsigned CntW  = ilid_pkg::CNT_W,
  parameter int unsigned Idx   = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  ilid_pkg::cell_ctrl_t   ctrl_i,
  input  logic [CntW-1:0]        pos_i,
  input  logic [DataW-1:0]       value_i,
  input  logic [DataW-1:0]       left_i,
  input  logic [DataW-1:0]       right_i,
  output logic [DataW-1:0]       data_o
);

  logic [DataW-1:0] data_q, data_d;
  logic [CntW-1:0]  idx;

  assign idx = CntW'(Idx);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (idx == pos_i) begin
        data_d = value_i;
      end else if (idx > pos_i) begin
        data_d = left_i;
      end
    end else if (ctrl_i.del) begin
      if (idx >= pos_i) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

>>> rtl/core/ilid_ctrl.sv
// Operation decode: status, effective position, cell control and next count.
module ilid_ctrl #(
  parameter int unsigned Capacity = ilid_pkg::CAPACITY,
  parameter int unsigned CntW     = ilid_pkg::CNT_W
) (
  input  logic [ilid_pkg::OP_W-1:0] op_i,
  input  logic [CntW-1:0]           pos_i,
  input  logic [CntW-1:0]           count_i,
  output ilid_pkg::cell_ctrl_t      ctrl_o,
  output logic [CntW-1:0]           eff_pos_o,
  output ilid_pkg::status_e         status_o,
  output logic                      is_read_o,
  output logic [CntW-1:0]           count_d_o
);

  logic full, empty;

  assign full  = (count_i == CntW'(Capacity));
  assign empty = (count_i == '0);

  always_comb begin
    ctrl_o    = '0;
    eff_pos_o = pos_i;
    status_o  = ilid_pkg::ST_OK;
    is_read_o = 1'b0;
    case (ilid_pkg::op_e'(op_i))
      ilid_pkg::OP_APPEND: begin
        eff_pos_o = count_i;
        if (full) status_o = ilid_pkg::ST_FULL;
        else      ctrl_o.ins = 1'b1;
      end
      ilid_pkg::OP_PREPEND: begin
        eff_pos_o = '0;
        if (full) status_o = ilid_pkg::ST_FULL;
        else      ctrl_o.ins = 1'b1;
      end
      ilid_pkg::OP_INSERT_AT: begin
        if (pos_i > count_i) status_o = ilid_pkg::ST_BAD_INDEX;
        else if (full)       status_o = ilid_pkg::ST_FULL;
        else                 ctrl_o.ins = 1'b1;
      end
      ilid_pkg::OP_READ_AT: begin
        is_read_o = 1'b1;
        if (pos_i >= count_i) status_o = ilid_pkg::ST_BAD_INDEX;
      end
      ilid_pkg::OP_DROP_HEAD: begin
        eff_pos_o = '0;
        if (empty) status_o = ilid_pkg::ST_EMPTY;
        else       ctrl_o.del = 1'b1;
      end
      ilid_pkg::OP_DROP_TAIL: begin
        eff_pos_o = count_i - CntW'(1);
        if (empty) status_o = ilid_pkg::ST_EMPTY;
        else       ctrl_o.del = 1'b1;
      end
      ilid_pkg::OP_DROP_AT: begin
        if (empty)                 status_o = ilid_pkg::ST_EMPTY;
        else if (pos_i >= count_i) status_o = ilid_pkg::ST_BAD_INDEX;
        else                       ctrl_o.del = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_d_o = count_i;
    if (ctrl_o.ins)      count_d_o = count_i + CntW'(1);
    else if (ctrl_o.del) count_d_o = count_i - CntW'(1);
  end

endmodule

>>> rtl/core/indexed_list_insert_delete.sv
// Top level of the indexed list: row of cells, decode, count and result register.
//
//   channel   signals                                   direction
//   in        in_valid_i in_ready_o op_i position_i     sink
//             item_value_i
//   out       out_valid_o out_ready_i read_value_o      source
//             status_o entry_count_o
//
// Every cell shifts or loads in parallel at accept.
// Results go to one output register; a new item is taken whenever that
// register is empty or being drained, so one item per cycle under no stall.
// Reset clears the count and the output valid; cell contents are not reset.
// A stalled output holds the input off until the result is taken.
module indexed_list_insert_delete #(
  parameter int unsigned CAPACITY = ilid_pkg::CAPACITY,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ilid_pkg::OP_W-1:0]     op_i,
  input  logic [CntW-1:0]               position_i,
  input  logic signed [ilid_pkg::DATA_W-1:0] item_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ilid_pkg::DATA_W-1:0] read_value_o,
  output logic [ilid_pkg::ST_W-1:0]     status_o,
  output logic [CntW-1:0]               entry_count_o
);

  localparam int unsigned DataW = ilid_pkg::DATA_W;

  logic                  accept;
  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q;
  logic [DataW-1:0]      rd_q, rd_d;
  ilid_pkg::status_e     st_q, st_d;
  logic [CntW-1:0]       cnt_out_q;
  ilid_pkg::cell_ctrl_t  ctrl;
  logic [CntW-1:0]       eff_pos;
  logic                  is_read;
  logic [DataW-1:0]      cell_q [CAPACITY];
  logic [DataW-1:0]      rd_sel;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ilid_ctrl #(
    .Capacity (CAPACITY),
    .CntW     (CntW)
  ) u_ctrl (
    .op_i      (op_i),
    .pos_i     (position_i),
    .count_i   (count_q),
    .ctrl_o    (ctrl),
    .eff_pos_o (eff_pos),
    .status_o  (st_d),
    .is_read_o (is_read),
    .count_d_o (count_d)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_q[g+1];
    end
    ilid_cell #(
      .DataW (DataW),
      .CntW  (CntW),
      .Idx   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (accept),
      .ctrl_i  (ctrl),
      .pos_i   (eff_pos),
      .value_i (item_value_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_q[g])
    );
  end

  // one-hot and-or read select
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (position_i == CntW'(i)) rd_sel = rd_sel | cell_q[i];
    end
  end

  always_comb begin
    if (st_d != ilid_pkg::ST_OK) rd_d = '1;
    else if (is_read)            rd_d = rd_sel;
    else                         rd_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q      <= rd_d;
      st_q      <= st_d;
      cnt_out_q <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = rd_q;
  assign status_o      = st_q;
  assign entry_count_o = cnt_out_q;

endmodule
